### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks on the date-time converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

### rtl/isoep_pkg.sv
// ----------------------------------------------------------------------------
// isoep_pkg
// Types and constants shared by the date-time to epoch seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package isoep_pkg;

  // Accepted string length range, in characters.
  localparam int unsigned MIN_LENGTH = 19;
  localparam int unsigned MAX_LENGTH = 32;

  // Result width and padded stream data width.
  localparam int unsigned EPOCH_W    = 42;
  localparam int unsigned OUT_DATA_W = 48;

  // Character codes of the accepted set.
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_Z     = 8'd90;

  // Progress through the seconds field.
  typedef enum logic [1:0] {
    SP_WAIT   = 2'd0,
    SP_SIGN   = 2'd1,
    SP_DIGITS = 2'd2,
    SP_DONE   = 2'd3
  } sec_phase_t;

  // Totals of one finished string, handed from the scanner to the math pipeline.
  typedef struct packed {
    logic                ok;
    logic                zone_on;
    logic                zone_neg;
    logic                colon;
    logic [3:0][7:0]     zone_chars;
    logic signed [16:0]  year;
    logic signed [9:0]   month;
    logic signed [9:0]   day;
    logic signed [9:0]   hour;
    logic signed [9:0]   minute;
    logic                sec_neg;
    logic [19:0]         sec_sum;
  } snap_t;

endpackage

`default_nettype wire

### rtl/isoep_scan.sv
// ----------------------------------------------------------------------------
// isoep_scan
// Per-character scanner: checks the string and accumulates the date fields.
// ----------------------------------------------------------------------------
`default_nettype none

module isoep_scan (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      in_char,
  input  wire logic            in_last,
  input  wire logic            apply_zone,
  output logic                 snap_valid,
  output isoep_pkg::snap_t     snap
);
  import isoep_pkg::*;

  // Running state of the string being received.
  typedef struct packed {
    logic [5:0]         cnt;
    logic               rej;
    logic signed [16:0] year;
    logic signed [9:0]  month;
    logic signed [9:0]  day;
    logic signed [9:0]  hour;
    logic signed [9:0]  minute;
    sec_phase_t         sph;
    logic               sneg;
    logic [19:0]        ssum;
    logic               zfound;
    logic               zneg;
    logic [5:0]         zpos;
    logic [3:0][7:0]    zch;
    logic               colon;
  } scan_st_t;

  scan_st_t          st_r;
  scan_st_t          st_upd;
  scan_st_t          st_nxt;
  logic signed [8:0] w;
  logic              is_digit;
  logic              is_sign;
  logic              char_ok;
  logic [5:0]        k;

  assign w        = $signed({1'b0, in_char}) - 9'sd48;
  assign is_digit = (in_char >= CH_0) && (in_char <= CH_9);
  assign is_sign  = (in_char == CH_PLUS) || (in_char == CH_MINUS);
  assign char_ok  = is_digit || is_sign || (in_char == CH_COLON) || (in_char == CH_DOT) ||
                    (in_char == CH_T) || (in_char == CH_Z);
  assign k        = st_r.cnt - st_r.zpos;

  // State after taking the current character.
  always_comb begin
    st_upd     = st_r;
    st_upd.cnt = (st_r.cnt == 6'd63) ? st_r.cnt : st_r.cnt + 6'd1;
    if (st_r.cnt == 6'd63) begin
      st_upd.rej = 1'b1;
    end else begin
      if (!char_ok) st_upd.rej = 1'b1;

      // Fixed positions: weighted digits and separators.
      case (st_r.cnt)
        6'd0:  st_upd.year   = st_r.year + 17'(w) * 17'sd1000;
        6'd1:  st_upd.year   = st_r.year + 17'(w) * 17'sd100;
        6'd2:  st_upd.year   = st_r.year + 17'(w) * 17'sd10;
        6'd3:  st_upd.year   = st_r.year + 17'(w);
        6'd5:  st_upd.month  = st_r.month + 10'(w) * 10'sd10;
        6'd6:  st_upd.month  = st_r.month + 10'(w);
        6'd8:  st_upd.day    = st_r.day + 10'(w) * 10'sd10;
        6'd9:  st_upd.day    = st_r.day + 10'(w);
        6'd11: st_upd.hour   = st_r.hour + 10'(w) * 10'sd10;
        6'd12: st_upd.hour   = st_r.hour + 10'(w);
        6'd14: st_upd.minute = st_r.minute + 10'(w) * 10'sd10;
        6'd15: st_upd.minute = st_r.minute + 10'(w);
        6'd4, 6'd7: begin
          if (in_char != CH_MINUS) st_upd.rej = 1'b1;
        end
        6'd10: begin
          if (in_char != CH_T) st_upd.rej = 1'b1;
        end
        6'd13, 6'd16: begin
          if (in_char != CH_COLON) st_upd.rej = 1'b1;
        end
        default: ;
      endcase

      // Seconds: optional sign, then leading digits.
      if ((st_r.cnt >= 6'd17) && (st_r.cnt <= 6'd22)) begin
        if ((st_r.sph == SP_WAIT) && is_sign) begin
          st_upd.sneg = (in_char == CH_MINUS);
          st_upd.sph  = SP_SIGN;
        end else if ((st_r.sph != SP_DONE) && is_digit) begin
          st_upd.ssum = st_r.ssum * 20'd10 + 20'(in_char - CH_0);
          st_upd.sph  = SP_DIGITS;
        end else begin
          st_upd.sph  = SP_DONE;
        end
      end

      // Zone offset: first sign from position 19, then the characters after it.
      if (st_r.cnt >= 6'd19) begin
        if (!st_r.zfound) begin
          if (is_sign) begin
            st_upd.zfound = 1'b1;
            st_upd.zneg   = (in_char == CH_MINUS);
            st_upd.zpos   = st_r.cnt;
          end
        end else begin
          if ((k >= 6'd1) && (k <= 6'd4)) st_upd.zch[2'(k - 6'd1)] = in_char;
          if (in_char == CH_COLON) st_upd.colon = 1'b1;
        end
      end
    end
  end

  // Next state: a final character restarts the scan.
  always_comb begin
    if (fire && in_last) begin
      st_nxt = '0;
    end else if (fire) begin
      st_nxt = st_upd;
    end else begin
      st_nxt = st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Totals of the finished string.
  always_comb begin
    snap_valid      = fire && in_last;
    snap.ok         = !st_upd.rej && (st_upd.cnt >= 6'(MIN_LENGTH)) &&
                      (st_upd.cnt <= 6'(MAX_LENGTH));
    snap.zone_on    = apply_zone && st_upd.zfound;
    snap.zone_neg   = st_upd.zneg;
    snap.colon      = st_upd.colon;
    snap.zone_chars = st_upd.zch;
    snap.year       = st_upd.year;
    snap.month      = st_upd.month;
    snap.day        = st_upd.day;
    snap.hour       = st_upd.hour;
    snap.minute     = st_upd.minute;
    snap.sec_neg    = st_upd.sneg;
    snap.sec_sum    = st_upd.ssum;
  end

endmodule

`default_nettype wire

### rtl/isoep_calc.sv
// ----------------------------------------------------------------------------
// isoep_calc
// Pipelined calendar arithmetic from field totals to epoch seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module isoep_calc (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                snap_valid,
  input  wire isoep_pkg::snap_t                    snap,
  output logic                                     snap_ready,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output logic signed [isoep_pkg::EPOCH_W-1:0]     res_epoch,
  output logic                                     res_ok
);
  import isoep_pkg::*;

  typedef struct packed {
    logic               ok;
    logic               zon;
    logic               zneg;
    logic signed [16:0] year;
    logic signed [9:0]  mon;
    logic signed [9:0]  day;
    logic signed [9:0]  hour;
    logic signed [9:0]  minute;
    logic signed [20:0] sec;
    logic [5:0]         q12;
    logic signed [12:0] zh;
    logic signed [12:0] zm;
  } sa_t;

  typedef struct packed {
    logic               ok;
    logic               zon;
    logic               zneg;
    logic signed [16:0] y;
    logic [3:0]         m;
    logic signed [9:0]  day;
    logic signed [23:0] hms;
    logic signed [24:0] off;
  } sb_t;

  typedef struct packed {
    logic               ok;
    logic signed [16:0] y;
    logic [7:0]         q400;
    logic [8:0]         doy;
    logic signed [9:0]  day;
    logic signed [25:0] hz;
  } sc_t;

  typedef struct packed {
    logic               ok;
    logic signed [8:0]  era;
    logic [8:0]         yoe;
    logic [8:0]         doy;
    logic signed [9:0]  day;
    logic signed [25:0] hz;
  } sd_t;

  typedef struct packed {
    logic               ok;
    logic signed [26:0] eday;
    logic [17:0]        doe;
    logic signed [9:0]  day;
    logic signed [25:0] hz;
  } se_t;

  typedef struct packed {
    logic               ok;
    logic signed [26:0] days;
    logic signed [25:0] hz;
  } sf_t;

  // Zone digit weight; an unfilled slot holds zero and weighs -48.
  function automatic logic signed [8:0] wz(input logic [7:0] c);
    return $signed({1'b0, c}) - 9'sd48;
  endfunction

  // Two zone digits as a signed two-digit value.
  function automatic logic signed [12:0] pair(input logic [7:0] hi, input logic [7:0] lo);
    return 13'(wz(hi)) * 13'sd10 + 13'(wz(lo));
  endfunction

  // Day of a March-based year on which month m (0 = January) starts.
  function automatic logic [8:0] doy_of(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  snap_t             s0_r;
  sa_t               sa_r, sa_nxt;
  sb_t               sb_r, sb_nxt;
  sc_t               sc_r, sc_nxt;
  sd_t               sd_r, sd_nxt;
  se_t               se_r, se_nxt;
  sf_t               sf_r, sf_nxt;
  logic [6:0]        v_r;
  logic [6:0]        take;
  logic              take_out;
  logic              out_valid_r;
  logic signed [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic              ok_r;

  logic signed [9:0]  a_mon;
  logic [9:0]         a_monb;
  logic [19:0]        a_prod;
  logic signed [6:0]  b_q;
  logic signed [10:0] b_mfull;
  logic [16:0]        c_yb;
  logic [34:0]        c_prod;
  logic signed [25:0] c_zoff;
  logic signed [17:0] d_yfull;
  logic [14:0]        e_p41;
  logic signed [43:0] g_t;

  // Stall chain: a stage loads when it is empty or the next one loads.
  always_comb begin
    take_out = !out_valid_r || res_ready;
    take[6]  = !v_r[6] || take_out;
    take[5]  = !v_r[5] || take[6];
    take[4]  = !v_r[4] || take[5];
    take[3]  = !v_r[3] || take[4];
    take[2]  = !v_r[2] || take[3];
    take[1]  = !v_r[1] || take[2];
    take[0]  = !v_r[0] || take[1];
  end

  assign snap_ready = take[0];

  // Stage A: month offset, month quotient by 12, zone digit pairs, signed seconds.
  always_comb begin
    a_mon      = s0_r.month - 10'sd1;
    a_monb     = 10'(11'(a_mon) + 11'sd60);
    a_prod     = a_monb * 10'd683;
    sa_nxt.ok     = s0_r.ok;
    sa_nxt.zon    = s0_r.zone_on;
    sa_nxt.zneg   = s0_r.zone_neg;
    sa_nxt.year   = s0_r.year;
    sa_nxt.mon    = a_mon;
    sa_nxt.day    = s0_r.day;
    sa_nxt.hour   = s0_r.hour;
    sa_nxt.minute = s0_r.minute;
    sa_nxt.sec    = s0_r.sec_neg ? -$signed({1'b0, s0_r.sec_sum}) :
                                    $signed({1'b0, s0_r.sec_sum});
    sa_nxt.q12    = a_prod[18:13];
    sa_nxt.zh     = pair(s0_r.zone_chars[0], s0_r.zone_chars[1]);
    sa_nxt.zm     = s0_r.colon ? pair(s0_r.zone_chars[2], s0_r.zone_chars[3]) :
                                 pair(s0_r.zone_chars[1], s0_r.zone_chars[2]);
  end

  // Stage B: month in year, March-based year, time of day, zone offset.
  always_comb begin
    b_q        = $signed({1'b0, sa_r.q12}) - 7'sd5;
    b_mfull    = 11'(sa_r.mon) - 11'(b_q) * 11'sd12;
    sb_nxt.ok  = sa_r.ok;
    sb_nxt.zon = sa_r.zon;
    sb_nxt.zneg = sa_r.zneg;
    sb_nxt.m   = b_mfull[3:0];
    sb_nxt.y   = sa_r.year + 17'(b_q) - ((b_mfull[3:0] <= 4'd1) ? 17'sd1 : 17'sd0);
    sb_nxt.day = sa_r.day;
    sb_nxt.hms = 24'(sa_r.hour) * 24'sd3600 + 24'(sa_r.minute) * 24'sd60 + 24'(sa_r.sec);
    sb_nxt.off = 25'(sa_r.zh) * 25'sd3600 + 25'(sa_r.zm) * 25'sd60;
  end

  // Stage C: quotient by 400 (biased positive), day of year, offset applied.
  always_comb begin
    c_yb       = sb_r.y + 17'sd5600;
    c_prod     = c_yb * 18'd167773;
    c_zoff     = !sb_r.zon ? 26'sd0 : (sb_r.zneg ? 26'(sb_r.off) : -26'(sb_r.off));
    sc_nxt.ok   = sb_r.ok;
    sc_nxt.y    = sb_r.y;
    sc_nxt.q400 = c_prod[33:26];
    sc_nxt.doy  = doy_of(sb_r.m);
    sc_nxt.day  = sb_r.day;
    sc_nxt.hz   = 26'(sb_r.hms) + c_zoff;
  end

  // Stage D: era and year of era.
  always_comb begin
    sd_nxt.ok  = sc_r.ok;
    sd_nxt.era = $signed({1'b0, sc_r.q400}) - 9'sd14;
    d_yfull    = 18'(sc_r.y) - 18'(sd_nxt.era) * 18'sd400;
    sd_nxt.yoe = d_yfull[8:0];
    sd_nxt.doy = sc_r.doy;
    sd_nxt.day = sc_r.day;
    sd_nxt.hz  = sc_r.hz;
  end

  // Stage E: day of era and days of whole eras.
  always_comb begin
    e_p41       = sd_r.yoe * 15'd41;
    se_nxt.ok   = sd_r.ok;
    se_nxt.doe  = 18'(sd_r.yoe) * 18'd365 + 18'(sd_r.yoe[8:2]) - 18'(e_p41[14:12]) +
                  18'(sd_r.doy);
    se_nxt.eday = 27'(sd_r.era) * 27'sd146097;
    se_nxt.day  = sd_r.day;
    se_nxt.hz   = sd_r.hz;
  end

  // Stage F: days since 1970-01-01.
  always_comb begin
    sf_nxt.ok   = se_r.ok;
    sf_nxt.days = se_r.eday + $signed({9'b0, se_r.doe}) + 27'(se_r.day) - 27'sd719469;
    sf_nxt.hz   = se_r.hz;
  end

  // Output: seconds, forced to zero for a rejected string.
  always_comb begin
    g_t       = 44'(sf_r.days) * 44'sd86400 + 44'(sf_r.hz);
    epoch_nxt = sf_r.ok ? g_t[EPOCH_W-1:0] : '0;
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    if (take[0]) s0_r <= snap;
    if (take[1]) sa_r <= sa_nxt;
    if (take[2]) sb_r <= sb_nxt;
    if (take[3]) sc_r <= sc_nxt;
    if (take[4]) sd_r <= sd_nxt;
    if (take[5]) se_r <= se_nxt;
    if (take[6]) sf_r <= sf_nxt;
    if (take_out) begin
      epoch_r <= epoch_nxt;
      ok_r    <= sf_r.ok;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take[0]) v_r[0] <= snap_valid;
      for (int i = 1; i < 7; i++) begin
        if (take[i]) v_r[i] <= v_r[i-1];
      end
      if (take_out) out_valid_r <= v_r[6];
    end
  end

  assign res_valid = out_valid_r;
  assign res_epoch = epoch_r;
  assign res_ok    = ok_r;

endmodule

`default_nettype wire

### rtl/iso8601_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// iso8601_to_epoch_seconds
// ISO 8601 date-time text to signed seconds since 1970-01-01 UTC.
// ----------------------------------------------------------------------------
// Characters are taken one per clock while in_tready is high, with in_tlast
// on the final one. Every character goes through the scanner in the cycle it
// is taken; the final one also loads the arithmetic pipeline (input register,
// stages A to F, output register), and a new string may follow in the very
// next cycle. Back-pressure on the output fills the pipeline before in_tready
// drops. A rejected string (bad length, character or separator) returns 0
// with the accepted flag low. No clearing pass after reset. The zone offset
// enable resets to enabled; the user must write it through cfg_we/cfg_wdata
// only while no string is in flight, as the block does not enforce this.
`default_nettype none

module iso8601_to_epoch_seconds (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: bit 0 enables the trailing zone offset.
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] character
  input  wire logic        in_tlast,   // last character of the string
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [isoep_pkg::OUT_DATA_W-1:0] out_tdata, // [41:0] epoch_seconds, rest zero
  output logic             out_tuser   // [0] accepted
);
  import isoep_pkg::*;

  logic                      apply_r;
  logic                      fire;
  logic                      snap_valid;
  snap_t                     snap;
  logic                      calc_ready;
  logic signed [EPOCH_W-1:0] res_epoch;
  logic                      res_ok;

  // Zone offset enable register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_r <= 1'b1;
    end else if (cfg_we) begin
      apply_r <= cfg_wdata;
    end
  end

  assign in_tready = calc_ready;
  assign fire      = in_tvalid && in_tready;

  isoep_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .apply_zone (apply_r),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  isoep_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (calc_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_epoch  (res_epoch),
    .res_ok     (res_ok)
  );

  // Result word packing.
  assign out_tdata = {(OUT_DATA_W - EPOCH_W)'(0), res_epoch};
  assign out_tuser = res_ok;

endmodule

`default_nettype wire

### rtl/isoep_chk.sv
// ----------------------------------------------------------------------------
// isoep_chk
// Port-level checks for the date-time converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module isoep_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result word holds.
  `ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // A rejected string reports zero seconds.
  `ASSERT_IMP(a_reject_zero, out_tvalid && !out_tuser, out_tdata == 48'd0, "rejected string gave nonzero seconds")

  // With the result side empty the pipeline has room for a character.
  `ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready, "input stalled with empty output")

  // Reset leaves no result pending.
  `ASSERT_RST(a_reset_empty, !out_tvalid, "result pending after reset")

endmodule

bind iso8601_to_epoch_seconds isoep_chk u_isoep_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### tb/sv/iso8601_to_epoch_seconds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_to_epoch_seconds_checker
// Watches the character and result streams of the date-time converter.
// ----------------------------------------------------------------------------
// Every character word taken on the input stream is scanned by a local copy of
// the converter's rules. On the final character of a string the expected epoch
// seconds and accepted flag are queued. Each result word taken on the output
// stream is compared against the oldest queued stamp. The zone offset enable
// is followed through the configuration write port.
module iso8601_to_epoch_seconds_checker
  import isoep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    errors,
  output int                    pending,
  output int                    results,
  output int                    accepted_cnt
);

  typedef struct packed {
    logic [EPOCH_W-1:0] secs;
    logic               ok;
  } stamp_result_t;

  stamp_result_t expected_stamps[$];

  // Scanner state of the string in flight.
  logic       zone_enable;
  int         n_chars;
  logic       bad;
  int         yr_acc, mo_acc, dy_acc, hr_acc, mi_acc;
  sec_phase_t sec_stage;
  logic       sec_neg;
  int         sec_val;
  logic       tz_seen, tz_neg, tz_colon;
  int         tz_at;
  logic [7:0] tz_text[5];

  function automatic void clear_scan();
    n_chars   = 0;
    bad       = 1'b0;
    yr_acc    = 0;
    mo_acc    = 0;
    dy_acc    = 0;
    hr_acc    = 0;
    mi_acc    = 0;
    sec_stage = SP_WAIT;
    sec_neg   = 1'b0;
    sec_val   = 0;
    tz_seen   = 1'b0;
    tz_neg    = 1'b0;
    tz_colon  = 1'b0;
    tz_at     = 0;
    for (int k = 0; k < 5; k++) tz_text[k] = 8'd0;
  endfunction

  function automatic logic legal_char(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 1'b1;
    case (c)
      CH_MINUS, CH_COLON, CH_T, CH_Z, CH_DOT, CH_PLUS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Fold one character into the running field sums.
  function automatic void scan_char(input logic [7:0] c);
    int   pos;
    int   w;
    int   k;
    logic is_digit;
    pos      = n_chars;
    w        = int'(c) - 48;
    is_digit = (c >= CH_0 && c <= CH_9);
    if (n_chars < 63) n_chars++;
    if (pos >= 63) begin
      bad = 1'b1;
      return;
    end
    if (!legal_char(c)) bad = 1'b1;

    case (pos)
      0: yr_acc += w * 1000;
      1: yr_acc += w * 100;
      2: yr_acc += w * 10;
      3: yr_acc += w;
      4, 7: if (c != CH_MINUS) bad = 1'b1;
      5: mo_acc += w * 10;
      6: mo_acc += w;
      8: dy_acc += w * 10;
      9: dy_acc += w;
      10: if (c != CH_T) bad = 1'b1;
      11: hr_acc += w * 10;
      12: hr_acc += w;
      13, 16: if (c != CH_COLON) bad = 1'b1;
      14: mi_acc += w * 10;
      15: mi_acc += w;
      default: ;
    endcase

    // Seconds: optional sign, then the leading run of digits.
    if (pos >= 17 && pos <= 22) begin
      if (sec_stage == SP_WAIT && (c == CH_PLUS || c == CH_MINUS)) begin
        sec_neg   = (c == CH_MINUS);
        sec_stage = SP_SIGN;
      end else if (sec_stage != SP_DONE && is_digit) begin
        sec_val   = sec_val * 10 + w;
        sec_stage = SP_DIGITS;
      end else begin
        sec_stage = SP_DONE;
      end
    end

    // Zone: the first sign from position 19 on, then up to five characters.
    if (pos >= 19) begin
      if (!tz_seen) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          tz_seen = 1'b1;
          tz_neg  = (c == CH_MINUS);
          tz_at   = pos;
        end
      end else begin
        k = pos - tz_at;
        if (k >= 1 && k <= 5) tz_text[k - 1] = c;
        if (c == CH_COLON) tz_colon = 1'b1;
      end
    end
  endfunction

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  // Days from 1970-01-01 to the first day of month m (1..12) of year y.
  function automatic longint civil_days(input longint y, input longint m);
    longint era, yoe, doy, doe;
    if (m <= 2) y -= 1;
    era = floor_div(y, 400);
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint zone_digit(input int k);
    return longint'(tz_text[k]) - 48;
  endfunction

  // Seconds since the epoch from the collected sums, with month carry.
  function automatic longint epoch_from_fields();
    longint mon0, yr, mo, secs, days, t, shift;
    int     mi_slot;
    mon0 = longint'(mo_acc) - 1;
    yr   = longint'(yr_acc) + floor_div(mon0, 12);
    mo   = mon0 - floor_div(mon0, 12) * 12;
    secs = sec_neg ? -longint'(sec_val) : longint'(sec_val);
    days = civil_days(yr, mo + 1) + longint'(dy_acc) - 1;
    t    = days * 86400 + longint'(hr_acc) * 3600 + longint'(mi_acc) * 60 + secs;
    if (zone_enable && tz_seen) begin
      mi_slot = tz_colon ? 2 : 1;
      shift   = (zone_digit(0) * 10 + zone_digit(1)) * 3600
              + (zone_digit(mi_slot) * 10 + zone_digit(mi_slot + 1)) * 60;
      t = tz_neg ? t + shift : t - shift;
    end
    return t;
  endfunction

  always @(posedge clk) begin
    stamp_result_t want;
    longint        t;
    logic          ok;
    if (!rst_n) begin
      clear_scan();
      zone_enable = 1'b1;
      expected_stamps.delete();
      errors       = 0;
      results      = 0;
      accepted_cnt = 0;
    end else begin
      if (cfg_we) zone_enable = cfg_wdata;

      // Result word: compare against the oldest queued stamp.
      if (out_tvalid && out_tready) begin
        results++;
        if (out_tuser) accepted_cnt++;
        if (expected_stamps.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result word with nothing pending: epoch %0d accepted %0b",
                     $time, $signed(out_tdata[EPOCH_W-1:0]), out_tuser);
        end else begin
          want = expected_stamps.pop_front();
          if (out_tdata[EPOCH_W-1:0] !== want.secs || out_tuser !== want.ok) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] result %0d: epoch exp %0d got %0d, accepted exp %0b got %0b",
                       $time, results, $signed(want.secs),
                       $signed(out_tdata[EPOCH_W-1:0]), want.ok, out_tuser);
          end
        end
      end

      // Character word: scan it, and queue a stamp on the final one.
      if (in_tvalid && in_tready) begin
        scan_char(in_tdata);
        if (in_tlast) begin
          ok = !bad && n_chars >= int'(MIN_LENGTH) && n_chars <= int'(MAX_LENGTH);
          t  = ok ? epoch_from_fields() : 64'sd0;
          want.secs = t[EPOCH_W-1:0];
          want.ok   = ok;
          expected_stamps.push_back(want);
          clear_scan();
        end
      end
    end
    pending = expected_stamps.size();
  end

endmodule

### tb/sv/iso8601_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_to_epoch_seconds_tb
// Stimulus and verdict for the date-time to epoch seconds converter.
// ----------------------------------------------------------------------------
// Sends hand-picked date-time strings first: field extremes, non-digit field
// characters, signed seconds, both zone forms, a zone cut short, every wrong
// separator, bad bytes and lengths around both limits. Then random strings,
// mostly well formed with random content, the rest broken or plain noise.
// The zone offset enable is switched between phases while nothing is in
// flight. Both streams idle at random, and once the result side holds off
// long enough to back the converter up into its input.
module iso8601_to_epoch_seconds_tb;
  import isoep_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we, cfg_wdata;
  logic                  in_tvalid, in_tready, in_tlast;
  logic [7:0]            in_tdata;
  logic                  out_tvalid, out_tready, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  int errors, pending, results, accepted_cnt;
  int chars_sent, strings_sent, cfg_writes;
  int stalls_asked, stalls_done;
  logic tx_quiet, rx_quiet;

  logic [7:0] text_buf[$];

  string samples[$] = '{
    "1970-01-01T00:00:00Z",
    "2016-01-11T14:28:00+02:00",
    "2016-01-11T14:28:00-0230",
    "2016-01-11T14:28:00+05",
    "9999-12-31T23:59:59.999999",
    "0000-00-00T00:00:00",
    "ZZZZ-ZZ-ZZTZZ:ZZ:ZZ",
    "++++-++-++T++:++:++",
    "2000-02-29T12:00:-5",
    "2000-02-29T12:00:+Z",
    "1999-12-31T23:59:123456",
    "2016:01-11T14:28:00",
    "2016-01+11T14:28:00",
    "2016-01-11Z14:28:00",
    "2016-01-11T14-28:00",
    "2016-01-11T14:28.00",
    "2016-01-11T14:28:0",
    "2016-01-11T14:28:00.1234567+0100",
    "2016-01-11T14:28:00.12345678+0100",
    "2038-01-19T03:14:07-1"
  };

  always #5 clk = ~clk;

  iso8601_to_epoch_seconds dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  iso8601_to_epoch_seconds_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .errors       (errors),
    .pending      (pending),
    .results      (results),
    .accepted_cnt (accepted_cnt)
  );

  // Idle lengths: often none, mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 5))
      0: return CH_MINUS;
      1: return CH_COLON;
      2: return CH_T;
      3: return CH_Z;
      4: return CH_DOT;
      default: return CH_PLUS;
    endcase
  endfunction

  function automatic void put_text(input string t);
    for (int i = 0; i < t.len(); i++) text_buf.push_back(t[i]);
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) text_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endfunction

  // Field characters are mostly digits, sometimes other legal symbols.
  function automatic void put_fields(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) text_buf.push_back(pick_symbol());
      else text_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void put_zone(input logic extended, input logic with_minutes);
    text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    put_fields(2);
    if (with_minutes) begin
      if (extended) text_buf.push_back(CH_COLON);
      put_fields(2);
    end
  endfunction

  // A well-formed date-time with random field content and a random tail.
  function automatic void build_stamp();
    text_buf.delete();
    put_fields(4);
    text_buf.push_back(CH_MINUS);
    put_fields(2);
    text_buf.push_back(CH_MINUS);
    put_fields(2);
    text_buf.push_back(CH_T);
    put_fields(2);
    text_buf.push_back(CH_COLON);
    put_fields(2);
    text_buf.push_back(CH_COLON);
    if ($urandom_range(0, 5) == 0) begin
      text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      put_fields(1);
    end else begin
      put_fields(2);
    end
    case ($urandom_range(0, 8))
      0: ;
      1: text_buf.push_back(CH_Z);
      2: begin
        text_buf.push_back(CH_DOT);
        put_digits($urandom_range(1, 9));
        if ($urandom_range(0, 1) == 1) text_buf.push_back(CH_Z);
      end
      3: put_zone(1'b1, 1'b1);
      4: put_zone(1'b0, 1'b1);
      5: put_zone(1'b0, 1'b0);
      6: begin
        text_buf.push_back(CH_DOT);
        put_digits($urandom_range(1, 6));
        put_zone(1'($urandom_range(0, 1)), 1'b1);
      end
      7: put_digits($urandom_range(1, 4));
      default: begin
        repeat ($urandom_range(1, 13)) begin
          if ($urandom_range(0, 1) == 1) text_buf.push_back(pick_symbol());
          else put_digits(1);
        end
      end
    endcase
  endfunction

  // Damage a stamp: separator, bad byte, length, or replace it with noise.
  function automatic void break_stamp();
    int slots[5] = '{4, 7, 10, 13, 16};
    int n;
    case ($urandom_range(0, 4))
      0: begin
        if ($urandom_range(0, 1) == 1)
          text_buf[slots[$urandom_range(0, 4)]] = pick_symbol();
        else
          text_buf[slots[$urandom_range(0, 4)]] = 8'($urandom_range(1, 255));
      end
      1: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
      2: begin
        n = $urandom_range(1, 18);
        while (text_buf.size() > n) void'(text_buf.pop_back());
      end
      3: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 72) : $urandom_range(33, 40);
        while (text_buf.size() < n) put_fields(1);
      end
      default: begin
        text_buf.delete();
        repeat ($urandom_range(1, 40)) text_buf.push_back(8'($urandom_range(1, 255)));
      end
    endcase
  endfunction

  // One character word; returns at the falling edge after it was taken.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(input string t);
    text_buf.delete();
    put_text(t);
    send_line();
  endtask

  // Wait until every queued stamp has come back, plus the pipeline depth.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_zone_offset(input logic on);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_random(input int strings);
    repeat (strings) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      build_stamp();
      if ($urandom_range(0, 99) < 30) break_stamp();
      send_line();
    end
  endtask

  // Result side: random holds, quiet stretches, and the long hold on request.
  initial begin : drain_side
    int hold;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_asked != stalls_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stalls_done++;
      end else if (!rst_n || rx_quiet) begin
        out_tready <= 1'b1;
      end else begin
        hold = pick_gap();
        if (hold == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (hold - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("iso8601_to_epoch_seconds verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'd0;
    in_tlast     = 1'b0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    chars_sent   = 0;
    strings_sent = 0;
    cfg_writes   = 0;
    stalls_asked = 0;
    stalls_done  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings with the zone offset at its reset value.
    foreach (samples[i]) send_text(samples[i]);

    // Byte zero inside the zone.
    text_buf.delete();
    put_text("2016-01-11T14:28:00+0100");
    text_buf[20] = 8'h00;
    send_line();

    // A high byte and a lowercase letter.
    text_buf.delete();
    put_text("2016-01-11T14:28:00a");
    text_buf[2] = 8'hFF;
    send_line();

    // Far too long: the character count saturates.
    text_buf.delete();
    put_text("2016-01-11T14:28:00");
    put_digits(51);
    send_line();

    // Zone offset off: the zone strings again, then random content.
    settle();
    set_zone_offset(1'b0);
    send_text(samples[1]);
    send_text(samples[2]);
    send_text(samples[3]);
    run_random(12);

    // Zone offset on, with one long hold on the result side.
    settle();
    set_zone_offset(1'b1);
    run_random(6);
    stalls_asked++;
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    repeat (16) begin
      build_stamp();
      send_line();
    end
    run_random(6);

    settle();
    set_zone_offset(1'b0);
    run_random(12);

    settle();
    set_zone_offset(1'b1);
    run_random(12);

    settle();
    $display("Sent %0d strings (%0d characters) across %0d zone offset settings.",
             strings_sent, chars_sent, cfg_writes + 1);
    $display("Checked %0d results, %0d accepted, %0d mismatches.",
             results, accepted_cnt, errors);
    if (errors == 0 && pending == 0)
      $display("iso8601_to_epoch_seconds verification clean");
    else
      $display("iso8601_to_epoch_seconds verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/isoep_pkg.sv
rtl/isoep_scan.sv
rtl/isoep_calc.sv
rtl/iso8601_to_epoch_seconds.sv
rtl/isoep_chk.sv
tb/sv/iso8601_to_epoch_seconds_checker.sv
tb/sv/iso8601_to_epoch_seconds_tb.sv
